// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the queue block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define FQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FQS_ASSERT_NOW(lbl, ante, cons, msg)
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/fqs_pkg.sv =====
// Shared types and codes for the FIFO queue with search.
// No dependencies; used by fqs_seq and the top level.
package fqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;

  // Operation codes
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_SRCH = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic        [1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } fqs_in_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic        [POS_W-1:0]  position;
  } fqs_out_t;

endpackage

// ===== rtl/fqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fqs_seq.sv =====
// Queue sequencer: head/tail/count pointers, ring store and the shared
// read-and-compare unit. Depends on fqs_pkg and fqs_ram.
module fqs_seq #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  fqs_pkg::fqs_in_t in_data,
  output logic             in_stall,
  output logic             res_valid,
  output fqs_pkg::fqs_out_t res_data,
  input  logic             res_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DEQ  = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [1:0]                        mode_r, mode_nxt;
  logic [fqs_pkg::DATA_W-1:0]        value_r, value_nxt;
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     tail_r, tail_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [AW-1:0]                     scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]                     cmp_k_r, cmp_k_nxt;
  fqs_pkg::fqs_out_t                 res_r, res_nxt;

  logic                              ram_we;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  logic [fqs_pkg::DATA_W-1:0]        ram_rdata;
  logic                              q_full;
  logic                              q_empty;
  logic                              scan_last;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
    wrap_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  fqs_ram #(
    .WIDTH (fqs_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (value_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_full    = (count_r == CW'(DEPTH));
  assign q_empty   = (count_r == '0);
  // entry under compare is the last occupied one
  assign scan_last = ((CW'(cmp_k_r) + 1'b1) == count_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_data  = res_r;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    value_nxt    = value_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    cmp_k_nxt    = cmp_k_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = head_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          value_nxt = in_data.value;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = fqs_pkg::STAT_OK;
        state_nxt      = ST_DONE;
        unique case (mode_r)
          fqs_pkg::MODE_ENQ: begin
            if (q_full) begin
              res_nxt.status = fqs_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              tail_nxt  = wrap_next(tail_r);
              count_nxt = count_r + 1'b1;
            end
          end
          fqs_pkg::MODE_DEQ: begin
            if (q_empty) begin
              res_nxt.status = fqs_pkg::STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              state_nxt = ST_DEQ;
            end
          end
          fqs_pkg::MODE_SRCH: begin
            if (q_empty) begin
              res_nxt.status = fqs_pkg::STAT_EMPTY;
            end else begin
              ram_re       = 1'b1;
              scan_idx_nxt = wrap_next(head_r);
              cmp_k_nxt    = '0;
              state_nxt    = ST_SRCH;
            end
          end
          default: begin
            // unused operation: no state change, all-zero result
          end
        endcase
      end
      ST_DEQ: begin
        res_nxt.data_out = ram_rdata;
        head_nxt         = wrap_next(head_r);
        count_nxt        = count_r - 1'b1;
        state_nxt        = ST_DONE;
      end
      ST_SRCH: begin
        // compare the entry read last cycle, fetch the next one
        priority if (ram_rdata == value_r) begin
          res_nxt.status   = fqs_pkg::STAT_OK;
          res_nxt.position = fqs_pkg::POS_W'(cmp_k_r);
          state_nxt        = ST_DONE;
        end else if (scan_last) begin
          res_nxt.status = fqs_pkg::STAT_NOTFOUND;
          state_nxt      = ST_DONE;
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r;
          scan_idx_nxt = wrap_next(scan_idx_r);
          cmp_k_nxt    = cmp_k_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    value_r    <= value_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_k_r    <= cmp_k_nxt;
    res_r      <= res_nxt;
  end

endmodule

// ===== rtl/fifo_queue_with_search_top.sv =====
// FIFO queue with search: top level with the result output register.
// Depends on fqs_pkg, fqs_seq (and through it fqs_ram) and assert_macros.svh.
//
// One transaction at a time is worked on. An enqueue passes through EXEC, a
// dequeue through EXEC and DEQ, and a search through EXEC and then SRCH for
// n compared entries, where n is the number of entries compared before a
// match or the end of the queue (at most DEPTH). Search speed is set by the
// single read port of the ring store: one stored entry is read and compared
// per cycle. A finished result sits in the output register, so the next input
// transaction can be taken while it waits; a result position beyond 15 is
// reported as its low four bits. No clearing pass follows reset.
`include "assert_macros.svh"

module fifo_queue_with_search_top #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fqs_pkg::fqs_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output fqs_pkg::fqs_out_t out_data,
  input  logic              out_stall
);

  logic              res_valid;
  logic              res_ready;
  fqs_pkg::fqs_out_t res_data;
  logic              out_valid_r;
  fqs_pkg::fqs_out_t out_data_r;

  fqs_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `FQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `FQS_ASSERT_NOW(a_result_while_busy, res_valid, in_stall, "result with sequencer idle")
  `FQS_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, out_valid, "result not registered")
  `FQS_ASSERT_NOW(a_data_only_ok, out_valid && (out_data.data_out != 0), out_data.status == fqs_pkg::STAT_OK, "data with bad status")

endmodule

// ===== test/fifo_queue_with_search_top_tb.sv =====
// Self-checking testbench for fifo_queue_with_search_top: directed table, then random traffic.
// Depends on fqs_pkg and the RTL of the queue block.
// Results are checked against a local queue model or the row's own expected result.
`timescale 1ns / 100ps

module fifo_queue_with_search_top_tb;

  localparam int Q_DEPTH      = fqs_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 60;    // tail of the run without idling
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 25;    // extra wait after the last expected result is checked

  // Mode 3 has no package code; the block ignores it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    fqs_pkg::fqs_in_t  req;
    bit                typed;   // row carries its own expected result
    fqs_pkg::fqs_out_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  fqs_pkg::fqs_in_t  in_data = '0;
  logic              in_stall;
  logic              out_valid;
  fqs_pkg::fqs_out_t out_data;
  logic              out_stall = 1'b0;

  // Queue model state
  logic signed [fqs_pkg::DATA_W-1:0] ring_copy [Q_DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned fill = 0;

  fqs_pkg::fqs_out_t pending_results [$];
  stim_row_t         dir_rows [$];
  int                fail_count = 0;
  int                op_bias = 2;
  bit                calm = 1'b0;

  fifo_queue_with_search_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the queue model and return its result
  function automatic fqs_pkg::fqs_out_t apply_queue_op(fqs_pkg::fqs_in_t req);
    fqs_pkg::fqs_out_t res;
    int unsigned idx;
    res = '0;
    case (req.mode)
      fqs_pkg::MODE_ENQ: begin
        if (fill >= Q_DEPTH) begin
          res.status = fqs_pkg::STAT_FULL;
        end else begin
          ring_copy[wr_ptr] = req.value;
          wr_ptr = (wr_ptr + 1) % Q_DEPTH;
          fill++;
        end
      end
      fqs_pkg::MODE_DEQ: begin
        if (fill == 0) begin
          res.status = fqs_pkg::STAT_EMPTY;
        end else begin
          res.data_out = ring_copy[rd_ptr];
          rd_ptr = (rd_ptr + 1) % Q_DEPTH;
          fill--;
        end
      end
      fqs_pkg::MODE_SRCH: begin
        if (fill == 0) begin
          res.status = fqs_pkg::STAT_EMPTY;
        end else begin
          res.status = fqs_pkg::STAT_NOTFOUND;
          for (int k = 0; k < fill; k++) begin
            idx = (rd_ptr + k) % Q_DEPTH;
            if (ring_copy[idx] == req.value) begin
              res.status   = fqs_pkg::STAT_OK;
              res.position = fqs_pkg::POS_W'(k);
              break;
            end
          end
        end
      end
      default: ;  // unused mode: no effect, all-zero result
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [1:0] mode,
                                  logic signed [fqs_pkg::DATA_W-1:0] value,
                                  bit typed = 1'b0,
                                  logic [1:0] status = fqs_pkg::STAT_OK,
                                  logic signed [fqs_pkg::DATA_W-1:0] data_out = '0,
                                  logic [fqs_pkg::POS_W-1:0] position = '0);
    stim_row_t row;
    row.req.mode       = mode;
    row.req.value      = value;
    row.typed          = typed;
    row.want.status    = status;
    row.want.data_out  = data_out;
    row.want.position  = position;
    dir_rows.push_back(row);
  endfunction

  // Value mix: a small pool for duplicates, the extremes, and full-range noise
  function automatic logic signed [fqs_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $signed($urandom_range(0, 7)) - 4;
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Random transaction shaped by the current fill/drain bias
  function automatic fqs_pkg::fqs_in_t make_random_request();
    fqs_pkg::fqs_in_t req;
    int r;
    int enq_lim;
    int deq_lim;
    r = $urandom_range(0, 99);
    case (op_bias)
      0:       begin enq_lim = 60; deq_lim = 75; end
      1:       begin enq_lim = 20; deq_lim = 60; end
      default: begin enq_lim = 35; deq_lim = 65; end
    endcase
    req.value = $urandom;
    if (r < enq_lim) begin
      req.mode  = fqs_pkg::MODE_ENQ;
      req.value = pick_value();
    end else if (r < deq_lim) begin
      req.mode = fqs_pkg::MODE_DEQ;
    end else if (r < 95) begin
      req.mode = fqs_pkg::MODE_SRCH;
      if (fill > 0 && $urandom_range(0, 99) < 60)
        req.value = ring_copy[(rd_ptr + $urandom_range(0, fill - 1)) % Q_DEPTH];
      else
        req.value = pick_value();
    end else begin
      req.mode = MODE_UNUSED;
    end
    return req;
  endfunction

  // Stimulus: reset, directed table, random traffic, drain, verdict
  initial begin
    fqs_pkg::fqs_in_t  req;
    fqs_pkg::fqs_out_t got;
    bit                typed;
    bit                send_idle_on;
    int                total;
    int                gap;

    // Empty queue, unused mode, signed extremes
    add_row(fqs_pkg::MODE_DEQ, '0, 1'b1, fqs_pkg::STAT_EMPTY);
    add_row(fqs_pkg::MODE_SRCH, '0, 1'b1, fqs_pkg::STAT_EMPTY);
    add_row(MODE_UNUSED, '1, 1'b1, fqs_pkg::STAT_OK);
    add_row(fqs_pkg::MODE_ENQ, 32'sh8000_0000, 1'b1, fqs_pkg::STAT_OK);
    add_row(fqs_pkg::MODE_ENQ, 32'sh7FFF_FFFF, 1'b1, fqs_pkg::STAT_OK);
    add_row(fqs_pkg::MODE_SRCH, 32'sh7FFF_FFFF);
    add_row(fqs_pkg::MODE_SRCH, '0);
    add_row(fqs_pkg::MODE_DEQ, '0, 1'b1, fqs_pkg::STAT_OK, 32'sh8000_0000);
    // Fill to the brim, with a duplicate and -1 last
    for (int i = 0; i < Q_DEPTH - 1; i++) begin
      if (i == 3 || i == 9)
        add_row(fqs_pkg::MODE_ENQ, 32'sh42);
      else if (i == Q_DEPTH - 2)
        add_row(fqs_pkg::MODE_ENQ, '1);
      else
        add_row(fqs_pkg::MODE_ENQ, 32'sh1357_0000 + i);
    end
    add_row(fqs_pkg::MODE_ENQ, 32'sh1, 1'b1, fqs_pkg::STAT_FULL);
    add_row(fqs_pkg::MODE_SRCH, '1);
    add_row(fqs_pkg::MODE_SRCH, 32'sh42);
    add_row(fqs_pkg::MODE_DEQ, '0, 1'b1, fqs_pkg::STAT_OK, 32'sh7FFF_FFFF);

    total = dir_rows.size() + RANDOM_ITEMS;
    send_idle_on = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      if (i < dir_rows.size()) begin
        req   = dir_rows[i].req;
        typed = dir_rows[i].typed;
      end else begin
        if ((i % 40) == 0) op_bias = $urandom_range(0, 2);
        req   = make_random_request();
        typed = 1'b0;
      end
      calm = (i >= total - CALM_ITEMS);
      if ((i % 32) == 0) send_idle_on = $urandom_range(0, 1);

      // Optional idle burst before this transaction
      gap = 0;
      if (!calm && send_idle_on && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= req;

      // Hold until accepted
      @(posedge clk);
      while (in_stall) @(posedge clk);

      got = apply_queue_op(req);
      if (typed) pending_results.push_back(dir_rows[i].want);
      else       pending_results.push_back(got);
    end
    in_valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result stall: random bursts, switched on and off in stretches
  initial begin
    int  stall_left;
    int  cyc;
    bit  recv_idle_on;
    stall_left   = 0;
    cyc          = 0;
    recv_idle_on = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc % 256) == 0) recv_idle_on = $urandom_range(0, 1);
      if (!rst_n || calm) begin
        out_stall  <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left--;
      end else if (recv_idle_on && $urandom_range(0, 99) < 15) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    fqs_pkg::fqs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data_out %0d position %0d",
               out_data.status, out_data.data_out, out_data.position);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %0d, actual %0d", want.data_out, out_data.data_out);
          fail_count++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) break;
    end
    $error("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
